[src/rect_grid_hit_test_assert.svh]
// assertion macros for the rectangle grid hit test block
// used by the port checker; needs a signal named i_clk and i_rst_n in scope
`ifndef RECT_GRID_HIT_TEST_ASSERT_SVH
`define RECT_GRID_HIT_TEST_ASSERT_SVH

// same-cycle implication, masked during reset
`define RGH_AST_NOW(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("rgh check failed");

// next-cycle implication, masked during reset
`define RGH_AST_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("rgh check failed");

// next-cycle implication that also holds across reset
`define RGH_AST_ALWAYS(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) (ant) |=> (con)) \
        else $error("rgh check failed");

`endif

[src/rgh_pkg.sv]
// shared types and constants for the rectangle grid hit test block
// no dependencies
package rgh_pkg;

    localparam int MAX_RECTS = 256;
    localparam int CNT_W     = $clog2(MAX_RECTS + 1);
    localparam int ADDR_W    = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int COORD_W   = 16;
    localparam int POINT_W   = 17;
    localparam int IDX_W     = 8;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        t_kind                      kind;
        logic [COORD_W-1:0]         left;
        logic [COORD_W-1:0]         top;
        logic [COORD_W-1:0]         right;
        logic [COORD_W-1:0]         bottom;
        logic                       last;
        logic signed [POINT_W-1:0]  px;
        logic signed [POINT_W-1:0]  py;
    } t_item;

endpackage

[src/rgh_front.sv]
// front end: accepts items and classifies them into a two-entry queue
// depends on rgh_pkg
module rgh_front import rgh_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic                       i_kind,
    input  logic [COORD_W-1:0]         i_rect_left,
    input  logic [COORD_W-1:0]         i_rect_top,
    input  logic [COORD_W-1:0]         i_rect_right,
    input  logic [COORD_W-1:0]         i_rect_bottom,
    input  logic                       i_last_rect,
    input  logic signed [POINT_W-1:0]  i_point_x,
    input  logic signed [POINT_W-1:0]  i_point_y,
    output logic                       o_vld,
    input  logic                       i_rdy,
    output t_item                      o_item
);

    t_item      r_buf [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;
    t_item      w_item;

    always_comb begin
        w_item.kind   = i_kind ? KIND_QUERY : KIND_LOAD;
        w_item.left   = i_rect_left;
        w_item.top    = i_rect_top;
        w_item.right  = i_rect_right;
        w_item.bottom = i_rect_bottom;
        w_item.last   = i_last_rect;
        w_item.px     = i_point_x;
        w_item.py     = i_point_y;
    end

    assign o_full = (r_cnt == 2'd2);
    assign o_vld  = (r_cnt != 2'd0);
    assign w_wr   = i_push && !o_full;
    assign w_rd   = o_vld && i_rdy;
    assign o_item = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_buf[r_wp] <= w_item;
    end

endmodule

[src/rgh_back.sv]
// back end: rectangle store, load handling, query scan and result register
// depends on rgh_pkg
module rgh_back import rgh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    output logic               o_rdy,
    input  t_item              i_item,
    output logic               o_empty,
    input  logic               i_pop,
    output logic               o_found,
    output logic [IDX_W-1:0]   o_char_index,
    output logic               o_overflow
);

    logic [4*COORD_W-1:0]      mem [MAX_RECTS];

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic                      r_ready, n_ready;
    logic                      r_drop, n_drop;
    logic [CNT_W-1:0]          r_addr, n_addr;
    logic                      r_rd_vld, n_rd_vld;
    logic [ADDR_W-1:0]         r_rd_idx;
    logic [4*COORD_W-1:0]      r_rd_data;
    logic signed [POINT_W-1:0] r_px, r_py;
    logic                      r_ovf;
    logic                      r_hit, n_hit;
    logic [ADDR_W-1:0]         r_idx, n_idx;
    logic                      r_out_vld, n_out_vld;
    logic                      r_out_found;
    logic [IDX_W-1:0]          r_out_idx;
    logic                      r_out_ovf;

    logic                      w_take, w_we, w_re, w_match, w_out_load;
    logic [CNT_W-1:0]          w_base;
    logic [COORD_W-1:0]        w_l, w_t, w_r, w_b;

    assign o_rdy   = (r_state == ST_IDLE);
    assign w_take  = i_vld && o_rdy;
    assign w_base  = r_ready ? '0 : r_count;
    assign w_re    = (r_state == ST_SCAN) && (r_addr != r_count);
    assign {w_l, w_t, w_r, w_b} = r_rd_data;

    // closed-box test; negative coordinates never match
    assign w_match = r_rd_vld &&
                     ($signed({1'b0, w_l}) <= r_px) && (r_px <= $signed({1'b0, w_r})) &&
                     ($signed({1'b0, w_t}) <= r_py) && (r_py <= $signed({1'b0, w_b}));

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ready    = r_ready;
        n_drop     = r_drop;
        n_addr     = r_addr;
        n_rd_vld   = 1'b0;
        n_hit      = r_hit;
        n_idx      = r_idx;
        n_out_vld  = r_out_vld && !i_pop;
        w_we       = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_take && i_item.kind == KIND_LOAD) begin
                    n_drop  = r_ready ? 1'b0 : r_drop;
                    n_count = w_base;
                    if (w_base < CNT_W'(MAX_RECTS)) begin
                        w_we    = 1'b1;
                        n_count = w_base + CNT_W'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    n_ready = i_item.last && (n_count != '0);
                end else if (w_take) begin
                    n_hit  = 1'b0;
                    n_idx  = '0;
                    n_addr = '0;
                    n_state = r_ready ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN: begin
                if (w_re) begin
                    n_addr   = r_addr + CNT_W'(1);
                    n_rd_vld = 1'b1;
                end
                if (w_match) begin
                    n_hit   = 1'b1;
                    n_idx   = r_rd_idx;
                    n_state = ST_RESULT;
                end else if (!w_re) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!n_out_vld) begin
                    w_out_load = 1'b1;
                    n_out_vld  = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_ready   <= 1'b0;
            r_drop    <= 1'b0;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ready   <= n_ready;
            r_drop    <= n_drop;
            r_addr    <= n_addr;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= n_hit;
        r_idx <= n_idx;
        if (w_take) begin
            r_px  <= i_item.px;
            r_py  <= i_item.py;
            r_ovf <= r_drop;
        end
        if (w_out_load) begin
            r_out_found <= r_hit;
            r_out_idx   <= IDX_W'(r_idx);
            r_out_ovf   <= r_ovf;
        end
    end

    // rectangle store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_base[ADDR_W-1:0]] <= {i_item.left, i_item.top,
                                              i_item.right, i_item.bottom};
        if (w_re) begin
            r_rd_data <= mem[r_addr[ADDR_W-1:0]];
            r_rd_idx  <= r_addr[ADDR_W-1:0];
        end
    end

    assign o_empty      = !r_out_vld;
    assign o_found      = r_out_found;
    assign o_char_index = r_out_idx;
    assign o_overflow   = r_out_ovf;

endmodule

[src/rect_grid_hit_test.sv]
// Rectangle hit test. Loads glyph rectangles (unsigned Q12.4) into a layout
// store; a load marked last closes the layout. A point query returns the
// lowest index of a stored rectangle whose closed box holds the point.
// Input channel: push/full, one item per transfer; kind selects load or query.
// Result channel: empty/pop; a query yields one result, a load none.
// A load is written to the store without leaving the idle state. A query
// scans the store through its single registered read port, one rectangle a
// cycle, stopping at the first hit; before a layout it goes straight to result.
// A two-entry queue in front lets items be taken while the back end works.
// The result register holds its value while pop is low; the back end waits
// in its result state until the register frees, and the queue fills behind.
// Reset empties the queue and the result register, clears the layout, count and overflow flag; the
// store itself is not cleared, only written entries are read.
// Depends on rgh_pkg, rgh_front and rgh_back.
module rect_grid_hit_test import rgh_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       i_kind,
    input  logic [COORD_W-1:0]         i_rect_left,
    input  logic [COORD_W-1:0]         i_rect_top,
    input  logic [COORD_W-1:0]         i_rect_right,
    input  logic [COORD_W-1:0]         i_rect_bottom,
    input  logic                       i_last_rect,
    input  logic signed [POINT_W-1:0]  i_point_x,
    input  logic signed [POINT_W-1:0]  i_point_y,
    output logic                       empty,
    input  logic                       pop,
    output logic                       o_found,
    output logic [IDX_W-1:0]           o_char_index,
    output logic                       o_overflow
);

    logic  w_vld, w_rdy;
    t_item w_item;

    rgh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_kind        (i_kind),
        .i_rect_left   (i_rect_left),
        .i_rect_top    (i_rect_top),
        .i_rect_right  (i_rect_right),
        .i_rect_bottom (i_rect_bottom),
        .i_last_rect   (i_last_rect),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .o_vld         (w_vld),
        .i_rdy         (w_rdy),
        .o_item        (w_item)
    );

    rgh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (w_vld),
        .o_rdy        (w_rdy),
        .i_item       (w_item),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_found      (o_found),
        .o_char_index (o_char_index),
        .o_overflow   (o_overflow)
    );

endmodule

[src/rgh_checker.sv]
// port-level checker for rect_grid_hit_test, bound to the top level
// depends on rgh_pkg and rect_grid_hit_test_assert.svh
`include "rect_grid_hit_test_assert.svh"

module rgh_port_props import rgh_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       push,
    input logic                       full,
    input logic                       empty,
    input logic                       pop,
    input logic                       o_found,
    input logic [IDX_W-1:0]           o_char_index,
    input logic                       o_overflow
);

    // a miss always reports index zero
    `RGH_AST_NOW(a_miss_idx, !empty && !o_found, o_char_index == '0)
    // reset leaves both sides empty
    `RGH_AST_ALWAYS(a_rst_clear, !i_rst_n, empty && !full)
    // a waiting result holds while stalled
    `RGH_AST_NEXT(a_hold, !empty && !pop,
        !empty && $stable(o_found) && $stable(o_char_index) && $stable(o_overflow))
    // with no push, a queue that is not full cannot become full
    `RGH_AST_NEXT(a_fill, $past(!full) && !full && !(push && !full) && !push, !full)

endmodule

bind rect_grid_hit_test rgh_port_props u_rgh_port_props (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_found      (o_found),
    .o_char_index (o_char_index),
    .o_overflow   (o_overflow)
);

[verif/rgh_checker.sv]
// result checker for the rectangle grid hit test block
// models the layout store and grid, predicts each query result; depends on rgh_pkg
`timescale 1ns / 1ps

module rgh_checker import rgh_pkg::*; #(
    parameter int GRID_ROWS_MAX = 8,
    parameter int GRID_COLS_MAX = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    input  logic                       full,
    input  logic                       i_kind,
    input  logic [COORD_W-1:0]         i_rect_left,
    input  logic [COORD_W-1:0]         i_rect_top,
    input  logic [COORD_W-1:0]         i_rect_right,
    input  logic [COORD_W-1:0]         i_rect_bottom,
    input  logic                       i_last_rect,
    input  logic signed [POINT_W-1:0]  i_point_x,
    input  logic signed [POINT_W-1:0]  i_point_y,
    input  logic                       empty,
    input  logic                       pop,
    input  logic                       o_found,
    input  logic [IDX_W-1:0]           o_char_index,
    input  logic                       o_overflow,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] index;
        logic             overflow;
    } t_hit;

    logic [COORD_W-1:0] lay_l [MAX_RECTS];
    logic [COORD_W-1:0] lay_t [MAX_RECTS];
    logic [COORD_W-1:0] lay_r [MAX_RECTS];
    logic [COORD_W-1:0] lay_b [MAX_RECTS];
    int unsigned lay_count;
    bit          lay_ready;
    bit          lay_dropped;
    int unsigned cw, ch, ncols, nrows;
    t_hit        hit_queue [$];

    function automatic int unsigned span(int unsigned lo, int unsigned hi);
        return hi > lo ? hi - lo : 0;
    endfunction

    function automatic int unsigned axis_cells(int unsigned s, int unsigned cs,
                                               int unsigned lim);
        int unsigned n;
        if (cs == 0) return 1;
        n = s / cs;
        if (n < 1) n = 1;
        if (n > lim) n = lim;
        return n;
    endfunction

    function automatic int unsigned cell_pick(int v, int unsigned cs, int unsigned n);
        int unsigned c;
        if (v < 0) v = 0;
        if (cs == 0) return 0;
        c = v / cs;
        return c > n - 1 ? n - 1 : c;
    endfunction

    task automatic build_layout();
        int unsigned bl, bt, br, bb, w, h;
        bl = lay_l[0]; bt = lay_t[0]; br = lay_r[0]; bb = lay_b[0];
        cw = 0; ch = 0;
        for (int i = 0; i < lay_count; i++) begin
            w = span(lay_l[i], lay_r[i]);
            h = span(lay_t[i], lay_b[i]);
            if (lay_l[i] < bl) bl = lay_l[i];
            if (lay_t[i] < bt) bt = lay_t[i];
            if (lay_r[i] > br) br = lay_r[i];
            if (lay_b[i] > bb) bb = lay_b[i];
            if (w > cw) cw = w;
            if (h > ch) ch = h;
        end
        ncols = axis_cells(span(bl, br), cw, GRID_COLS_MAX);
        nrows = axis_cells(span(bt, bb), ch, GRID_ROWS_MAX);
        lay_ready = 1;
    endtask

    function automatic t_hit predict_hit(int px, int py);
        t_hit res;
        int unsigned qc, qr, c0, c1, r0, r1, tmp;
        res = '0;
        if (lay_ready) begin
            qc = cell_pick(px, cw, ncols);
            qr = cell_pick(py, ch, nrows);
            for (int i = 0; i < lay_count && !res.found; i++) begin
                c0 = cell_pick(lay_l[i], cw, ncols);
                c1 = cell_pick(lay_r[i], cw, ncols);
                r0 = cell_pick(lay_t[i], ch, nrows);
                r1 = cell_pick(lay_b[i], ch, nrows);
                if (c0 > c1) begin tmp = c0; c0 = c1; c1 = tmp; end
                if (r0 > r1) begin tmp = r0; r0 = r1; r1 = tmp; end
                if (qc < c0 || qc > c1 || qr < r0 || qr > r1) continue;
                if (int'(lay_l[i]) <= px && px <= int'(lay_r[i]) &&
                    int'(lay_t[i]) <= py && py <= int'(lay_b[i])) begin
                    res.found = 1;
                    res.index = i[IDX_W-1:0];
                end
            end
        end
        res.overflow = lay_dropped;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_hit want;
        if (!i_rst_n) begin
            lay_count   = 0;
            lay_ready   = 0;
            lay_dropped = 0;
            cw = 0; ch = 0; ncols = 1; nrows = 1;
            hit_queue.delete();
            o_fail_count = 0;
            o_pending = 0;
        end else begin
            if (push && !full) begin
                if (t_kind'(i_kind) == KIND_LOAD) begin
                    if (lay_ready) begin
                        lay_ready = 0;
                        lay_count = 0;
                        lay_dropped = 0;
                    end
                    if (lay_count < MAX_RECTS) begin
                        lay_l[lay_count] = i_rect_left;
                        lay_t[lay_count] = i_rect_top;
                        lay_r[lay_count] = i_rect_right;
                        lay_b[lay_count] = i_rect_bottom;
                        lay_count++;
                    end else begin
                        lay_dropped = 1;
                    end
                    if (i_last_rect && lay_count > 0) build_layout();
                end else begin
                    want = predict_hit(int'(i_point_x), int'(i_point_y));
                    hit_queue = {hit_queue, want};
                end
            end
            if (pop && !empty) begin
                if (hit_queue.size() == 0) begin
                    $error("result transfer with no query outstanding");
                    o_fail_count++;
                end else begin
                    want = hit_queue.pop_front();
                    if (o_found !== want.found) begin
                        $error("found: expected %0d actual %0d", want.found, o_found);
                        o_fail_count++;
                    end
                    if (o_char_index !== want.index) begin
                        $error("char_index: expected %0d actual %0d",
                               want.index, o_char_index);
                        o_fail_count++;
                    end
                    if (o_overflow !== want.overflow) begin
                        $error("overflow: expected %0d actual %0d",
                               want.overflow, o_overflow);
                        o_fail_count++;
                    end
                end
            end
            o_pending = hit_queue.size();
        end
    end

endmodule

[verif/tb.sv]
// testbench top for the rectangle grid hit test block
// drives load and query transfers with random idling; depends on rgh_pkg, rgh_checker
`timescale 1ns / 1ps

module tb;
    import rgh_pkg::*;

    logic                      i_clk = 0;
    logic                      i_rst_n = 0;
    logic                      push = 0;
    logic                      full;
    logic                      i_kind = 0;
    logic [COORD_W-1:0]        i_rect_left = 0, i_rect_top = 0;
    logic [COORD_W-1:0]        i_rect_right = 0, i_rect_bottom = 0;
    logic                      i_last_rect = 0;
    logic signed [POINT_W-1:0] i_point_x = 0, i_point_y = 0;
    logic                      empty;
    logic                      pop = 0;
    logic                      o_found;
    logic [IDX_W-1:0]          o_char_index;
    logic                      o_overflow;
    int                        fail_count, pending;
    int                        send_idle_pct = 0, recv_stall_pct = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    rect_grid_hit_test i_dut (.*);
    rgh_checker i_chk (.*, .o_fail_count(fail_count), .o_pending(pending));

    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // push stays high from one transfer into the next; the idle loop drops it
    task automatic send(logic kind, logic [15:0] l, logic [15:0] t, logic [15:0] r,
                        logic [15:0] b, logic last, logic [16:0] x, logic [16:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_kind <= kind;
        i_rect_left <= l; i_rect_top <= t; i_rect_right <= r; i_rect_bottom <= b;
        i_last_rect <= last;
        i_point_x <= x; i_point_y <= y;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic put_rect(logic [15:0] l, logic [15:0] t, logic [15:0] r,
                            logic [15:0] b, logic last);
        send(KIND_LOAD, l, t, r, b, last, 17'($urandom), 17'($urandom));
    endtask

    task automatic ask(logic [16:0] x, logic [16:0] y);
        send(KIND_QUERY, 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), 1'($urandom_range(1)), x, y);
    endtask

    // random point, mostly near the layout span, sometimes negative or far out
    function automatic logic [16:0] rand_coord(int unsigned hi);
        case ($urandom_range(9))
            0: return -17'($urandom_range(65536, 1));
            1: return 17'($urandom_range(65535));
            default: return 17'($urandom_range(hi));
        endcase
    endfunction

    task automatic random_layout(int unsigned n, int unsigned span_hi);
        int unsigned l, t, w, h;
        for (int i = 0; i < n; i++) begin
            l = $urandom_range(span_hi);
            t = $urandom_range(span_hi);
            w = $urandom_range(4) == 0 ? $urandom_range(65535) : $urandom_range(400);
            h = $urandom_range(4) == 0 ? $urandom_range(65535) : $urandom_range(400);
            if ($urandom_range(15) == 0)   // reversed edges
                put_rect(16'(l + w), 16'(t), 16'(l), 16'(t + h), i == n - 1);
            else
                put_rect(16'(l), 16'(t), 16'(l + w), 16'(t + h), i == n - 1);
        end
    endtask

    initial begin
        int unsigned n, span_hi;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: query before build, extremes, zero size, negatives
        ask(17'd0, 17'd0);
        put_rect(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1);
        ask(17'h0ffff, 17'h0ffff);
        ask(17'h10000, 17'h10000);
        ask(17'h1ffff, 17'h0ffff);
        put_rect(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        put_rect(16'd10, 16'd10, 16'd100, 16'd200, 1'b0);
        put_rect(16'd200, 16'd5, 16'd50, 16'd300, 1'b0);
        put_rect(16'd0, 16'd0, 16'hffff, 16'hffff, 1'b1);
        ask(17'd0, 17'd0);
        ask(17'd50, 17'd100);
        ask(17'd100, 17'd200);
        ask(17'd150, 17'd100);
        ask(17'h1fff0, 17'd50);
        ask(17'h0aaaa, 17'h05555);
        // capacity: overflow a layout
        for (int i = 0; i < MAX_RECTS + 3; i++)
            put_rect(16'(i * 7), 16'(i * 3), 16'(i * 7 + 6), 16'(i * 3 + 9),
                     i == MAX_RECTS + 2);
        ask(17'd13, 17'd6);
        ask(17'(255 * 7), 17'(255 * 3));
        // new layout clears overflow
        put_rect(16'h5555, 16'haaaa, 16'haaaa, 16'hffff, 1'b1);
        ask(17'h08000, 17'h0c000);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 6 : 58) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 6 : 58) : 0;
            for (int k = 0; k < 6; k++) begin
                n = $urandom_range(3) == 0 ? $urandom_range(40, 1) : $urandom_range(6, 1);
                span_hi = $urandom_range(1) ? 2000 : 65535;
                random_layout(n, span_hi);
                repeat ($urandom_range(12, 3)) ask(rand_coord(span_hi), rand_coord(span_hi));
            end
        end
        push <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[rect_grid_hit_test.f]
+incdir+src
src/rgh_pkg.sv
src/rgh_front.sv
src/rgh_back.sv
src/rect_grid_hit_test.sv
src/rgh_checker.sv
verif/rgh_checker.sv
verif/tb.sv
